// ===== rtl/rbfk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the radial basis function kernel evaluator.
package rbfk_pkg;

  typedef enum logic [1:0] {
    KT_GAUSSIAN,
    KT_MULTIQUADRIC,
    KT_INV_MULTIQUADRIC,
    KT_INV_QUADRATIC
  } kernel_t;

  typedef enum logic [1:0] {
    CFG_KERNEL_TYPE,
    CFG_SHAPE_FACTOR,
    CFG_DIMS_IN_USE,
    CFG_UNUSED
  } cfg_index_t;

  localparam int GAUSS_LAT = 42;

endpackage

// ===== rtl/rbfk_gauss.sv =====
`timescale 1ns / 1ps
// Pipelined Gaussian lane: Horner series of exp(-u/16), four squarings and rounding.
module rbfk_gauss #(
  parameter int UW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [UW-1:0] u,
  output logic          out_valid,
  output logic [31:0]   val
);
  import rbfk_pkg::*;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  logic [31:0] ge [0:12];
  logic [30:0] gx [0:12];
  logic        gz [0:12];
  logic        gv [0:12];
  logic [31:0] sqe [0:4];
  logic        sqz [0:4];
  logic        sqv [0:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      gv[0] <= 1'b0;
    end else begin
      gv[0] <= in_valid;
    end
    gz[0] <= u >= (UW'(16) << 16);
    gx[0] <= {u[19:0], 11'b0};
    ge[0] <= ONE_Q31;
  end

  for (genvar g = 0; g < 12; g++) begin : g_step
    localparam int K = 12 - g;
    logic [30:0] an, bn, bq;
    logic [30:0] ax, bx;
    logic        az, bz, av, bv;
    logic [62:0] prod;

    assign prod = 63'(gx[g]) * 63'(ge[g]);

    always_ff @(posedge clk) begin
      if (rst) begin
        av <= 1'b0;
        bv <= 1'b0;
        gv[g+1] <= 1'b0;
      end else begin
        av <= gv[g];
        bv <= av;
        gv[g+1] <= bv;
      end
      an <= prod[61:31];
      ax <= gx[g];
      az <= gz[g];
      bn <= an;
      bx <= ax;
      bz <= az;
      gx[g+1] <= bx;
      gz[g+1] <= bz;
    end

    if (K > 1) begin : g_div
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
      logic [62:0] m;
      logic [35:0] rem;
      logic [30:0] q;
      assign m = 63'(an) * 63'(RECIP);
      assign rem = 36'(bn) - 36'(bq) * 36'(K);
      assign q = (rem >= 36'(K)) ? bq + 31'd1 : bq;
      always_ff @(posedge clk) begin
        bq <= m[62:32];
        ge[g+1] <= ONE_Q31 - 32'(q);
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        bq <= an;
        ge[g+1] <= ONE_Q31 - 32'(bq);
      end
    end
  end

  assign sqe[0] = ge[12];
  assign sqz[0] = gz[12];
  assign sqv[0] = gv[12];

  for (genvar i = 0; i < 4; i++) begin : g_square
    logic [63:0] p;
    assign p = 64'(sqe[i]) * 64'(sqe[i]) + 64'h4000_0000;
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[i+1] <= 1'b0;
      end else begin
        sqv[i+1] <= sqv[i];
      end
      sqe[i+1] <= p[62:31];
      sqz[i+1] <= sqz[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sqv[4];
    end
    val <= sqz[4] ? 32'd0 : ((sqe[4] + 32'h0000_4000) >> 15);
  end

endmodule

// ===== rtl/rbfk_root.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider followed by a pipelined square root, with final rounding.
module rbfk_root #(
  parameter int WW = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  rbfk_pkg::kernel_t kernel_type,
  input  logic             in_valid,
  input  logic [WW-1:0]    w,
  output logic             out_valid,
  output logic [31:0]      val,
  output logic             flag
);
  import rbfk_pkg::*;

  localparam int NUM_W = 51;
  localparam int QB = 35;
  localparam int XW = (WW + 16 > 33) ? WW + 16 : 33;
  localparam int SQB = (XW + 1) / 2;
  localparam int XP = 2 * SQB;

  logic [NUM_W-1:0] num;
  logic             dv [0:QB];
  logic [WW-1:0]    drem [0:QB];
  logic [WW-1:0]    dw [0:QB];
  logic [QB-1:0]    dnum [0:QB];
  logic [QB-1:0]    dq [0:QB];

  logic             sv [0:SQB];
  logic [XP-1:0]    sx [0:SQB];
  logic [SQB:0]     srem [0:SQB];
  logic [SQB-1:0]   sroot [0:SQB];
  logic [1:0]       sf [0:SQB];
  logic [31:0]      sq [0:SQB];

  assign num = (kernel_type == KT_INV_MULTIQUADRIC) ? (NUM_W'(1) << 50)
             : (NUM_W'(1) << 32) + NUM_W'(w >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
    end
    drem[0] <= WW'(num[NUM_W-1:QB]);
    dnum[0] <= num[QB-1:0];
    dq[0]   <= '0;
    dw[0]   <= w;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [WW:0] trial, diff;
    logic        ge;
    assign trial = {drem[s], dnum[s][QB-1]};
    assign diff = trial - {1'b0, dw[s]};
    assign ge = trial >= {1'b0, dw[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= dv[s];
      end
      drem[s+1] <= ge ? diff[WW-1:0] : trial[WW-1:0];
      dq[s+1]   <= {dq[s][QB-2:0], ge};
      dnum[s+1] <= dnum[s] << 1;
      dw[s+1]   <= dw[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= dv[QB];
    end
    sx[0]    <= (kernel_type == KT_MULTIQUADRIC) ? (XP'(dw[QB]) << 16) : XP'(dq[QB] >> 2);
    srem[0]  <= '0;
    sroot[0] <= '0;
    sf[0]    <= dq[QB][1:0];
    sq[0]    <= dq[QB][31:0];
  end

  for (genvar s = 0; s < SQB; s++) begin : g_sqrt
    logic [SQB+2:0] cur, trl, dif;
    logic           ge;
    assign cur = {srem[s], sx[s][XP-1 -: 2]};
    assign trl = {1'b0, sroot[s], 2'b01};
    assign dif = cur - trl;
    assign ge = cur >= trl;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s+1] <= 1'b0;
      end else begin
        sv[s+1] <= sv[s];
      end
      srem[s+1]  <= ge ? dif[SQB:0] : cur[SQB:0];
      sroot[s+1] <= {sroot[s][SQB-2:0], ge};
      sx[s+1]    <= sx[s] << 2;
      sf[s+1]    <= sf[s];
      sq[s+1]    <= sq[s];
    end
  end

  logic         up_mq, up_imq;
  logic [SQB:0] rr;
  logic [31:0]  val_next;
  logic         flag_next;

  assign up_mq = srem[SQB] > {1'b0, sroot[SQB]};
  assign up_imq = {srem[SQB], sf[SQB]} >= {1'b0, sroot[SQB], 2'b01};

  always_comb begin
    rr = (SQB + 1)'(sroot[SQB]);
    val_next = sq[SQB];
    flag_next = 1'b0;
    case (kernel_type)
      KT_MULTIQUADRIC: begin
        rr = (SQB + 1)'(sroot[SQB]) + (SQB + 1)'(up_mq);
        flag_next = 64'(rr) > 64'hFFFF_FFFF;
        val_next = flag_next ? 32'hFFFF_FFFF : 32'(rr);
      end
      KT_INV_MULTIQUADRIC: begin
        rr = (SQB + 1)'(sroot[SQB]) + (SQB + 1)'(up_imq);
        val_next = 32'(rr);
      end
      default: begin
        val_next = sq[SQB];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[SQB];
    end
    val  <= val_next;
    flag <= flag_next;
  end

endmodule

// ===== rtl/rbf_kernel_evaluator.sv =====
`timescale 1ns / 1ps
// Radial basis function kernel evaluator: one point pair in, one kernel word out.
// A word is taken in every cycle; busy never rises, so throughput is one word per cycle.
// The done latency is set by the one-bit-per-stage divider and square root pipelines.
// Synchronous reset clears the pipeline valid bits and restores the configuration registers.
module rbf_kernel_evaluator #(
  parameter int MAX_DIMS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] first_z,
  input  logic signed [15:0] first_w,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] second_z,
  input  logic signed [15:0] second_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [31:0]        kernel_value,
  output logic               saturated
);
  import rbfk_pkg::*;

  localparam int SW = 32 + $clog2(MAX_DIMS);
  localparam int WW = SW + 1;
  localparam int HW = 32 + SW - 17;
  localparam int XW = (WW + 16 > 33) ? WW + 16 : 33;
  localparam int SQB = (XW + 1) / 2;
  localparam int ROOT_LAT = 38 + SQB;
  localparam int PAD = ROOT_LAT - GAUSS_LAT;
  localparam int TOT = 6 + ROOT_LAT;

  kernel_t     kernel_type;
  logic [15:0] shape_factor;
  logic [2:0]  dims_in_use;
  logic [31:0] s2;

  logic signed [15:0] pa [0:3];
  logic signed [15:0] pb [0:3];
  logic [15:0] m1 [0:MAX_DIMS-1];
  logic [31:0] sq2 [0:MAX_DIMS-1];
  logic [SW-1:0] sum3;
  logic [HW-1:0] hi4;
  logic [48:0]   lo4;
  logic [SW-1:0] u5;
  logic [49:0]   low_sum;
  logic v1, v2, v3, v4, v5;

  logic        gv_out, rv_out, r_flag;
  logic [31:0] g_val, r_val;
  logic [31:0] gd_val [0:PAD-1];
  logic        gd_v [0:PAD-1];
  logic [31:0] value_next;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_type  <= KT_GAUSSIAN;
      shape_factor <= 16'd256;
      dims_in_use  <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_KERNEL_TYPE:  kernel_type  <= kernel_t'(cfg_data[1:0]);
        CFG_SHAPE_FACTOR: shape_factor <= cfg_data;
        CFG_DIMS_IN_USE:  dims_in_use  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
    s2 <= 32'(shape_factor) * 32'(shape_factor);
  end

  assign pa[0] = first_x;
  assign pa[1] = first_y;
  assign pa[2] = first_z;
  assign pa[3] = first_w;
  assign pb[0] = second_x;
  assign pb[1] = second_y;
  assign pb[2] = second_z;
  assign pb[3] = second_w;

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    logic signed [16:0] d;
    logic [16:0]        mag;
    logic               use_lane;
    if (i < 4) begin : g_port
      assign d = 17'(pa[i]) - 17'(pb[i]);
    end else begin : g_none
      assign d = '0;
    end
    assign mag = d[16] ? -d : d;
    assign use_lane = {1'b0, 3'(i)} < {1'b0, dims_in_use};
    always_ff @(posedge clk) begin
      m1[i]  <= use_lane ? mag[15:0] : 16'd0;
      sq2[i] <= 32'(m1[i]) * 32'(m1[i]);
    end
  end

  always_ff @(posedge clk) begin
    logic [SW-1:0] acc;
    acc = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      acc = acc + SW'(sq2[i]);
    end
    sum3 <= acc;
    hi4  <= HW'(s2) * HW'(sum3 >> 17);
    lo4  <= 49'(s2) * 49'(sum3[16:0]);
    u5   <= SW'(hi4 >> 15) + SW'(low_sum >> 32);
  end

  assign low_sum = 50'({hi4[14:0], 17'b0}) + 50'(lo4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  rbfk_gauss #(.UW(SW)) u_gauss (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .u         (u5),
    .out_valid (gv_out),
    .val       (g_val)
  );

  rbfk_root #(.WW(WW)) u_root (
    .clk         (clk),
    .rst         (rst),
    .kernel_type (kernel_type),
    .in_valid    (v5),
    .w           (WW'(u5) + WW'(32'h0001_0000)),
    .out_valid   (rv_out),
    .val         (r_val),
    .flag        (r_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAD; i++) begin
        gd_v[i] <= 1'b0;
      end
    end else begin
      gd_v[0] <= gv_out;
      for (int i = 1; i < PAD; i++) begin
        gd_v[i] <= gd_v[i-1];
      end
    end
    gd_val[0] <= g_val;
    for (int i = 1; i < PAD; i++) begin
      gd_val[i] <= gd_val[i-1];
    end
  end

  always_comb begin
    case (kernel_type)
      KT_GAUSSIAN: value_next = gd_val[PAD-1];
      default:     value_next = r_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rv_out;
    end
    kernel_value <= value_next;
    saturated    <= (kernel_type == KT_MULTIQUADRIC) && r_flag;
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) gd_v[PAD-1] == rv_out)
    else $error("Gaussian and root lanes out of step");
  a_latency: assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##TOT done)
    else $error("Accepted word did not complete at the expected latency");
  a_sat_kind: assert property (@(posedge clk) disable iff (rst)
      saturated |-> (done && kernel_type == KT_MULTIQUADRIC && kernel_value == 32'hFFFF_FFFF))
    else $error("Saturation flag outside a clipped multiquadric word");

endmodule
